### rtl/mesh_frame_header_filter_core_assert.svh
// Assertion macros for the mesh frame header filter.
// Each expects clk and rst in the scope where it is used.
`ifndef MESH_FRAME_HEADER_FILTER_CORE_ASSERT_SVH
`define MESH_FRAME_HEADER_FILTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MFHF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MFHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFHF_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MFHF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/mfhf_pkg.sv
package mfhf_pkg;

  localparam int unsigned PADDR_W = 4;

  localparam logic [7:0] HDR_BYTES       = 8'd26;
  localparam logic [7:0] HDR_LAST        = 8'd25;
  localparam int unsigned HDR_STORE_BYTES = 25;
  localparam logic [7:0] MAX_FRAME_BYTES = 8'd255;

  localparam logic [7:0]  MAGIC_0     = 8'h54;
  localparam logic [7:0]  MAGIC_1     = 8'h4D;
  localparam logic [7:0]  MAGIC_2     = 8'h4C;
  localparam logic [7:0]  MAGIC_3     = 8'h31;
  localparam logic [7:0]  HDR_VERSION = 8'h01;
  localparam logic [31:0] BCAST_ID    = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_HEADER     = 3'd0,
    ST_PAYLOAD    = 3'd1,
    ST_SHORT      = 3'd2,
    ST_BAD_MAGIC  = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_NOT_ADDR   = 3'd5,
    ST_BAD_KIND   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_OWN_NODE     = 2'd0,
    REG_TEXT_KIND    = 2'd1,
    REG_APPDATA_KIND = 2'd2
  } reg_idx_t;

  typedef struct packed {
    status_t     status;
    logic        frame_kind;
    logic [7:0]  channel_number;
    logic [31:0] source_node;
    logic [31:0] dest_node;
    logic [31:0] message_id;
    logic [31:0] port_number;
    logic [7:0]  payload_length;
    logic        direct;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

endpackage

### rtl/mfhf_rx_if.sv
interface mfhf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] frame_length;
  logic       first_byte;

  modport source (output valid, rx_byte, frame_length, first_byte, input ready);
  modport sink   (input valid, rx_byte, frame_length, first_byte, output ready);
endinterface

### rtl/mfhf_res_if.sv
interface mfhf_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        frame_kind;
  logic [7:0]  channel_number;
  logic [31:0] source_node;
  logic [31:0] dest_node;
  logic [31:0] message_id;
  logic [31:0] port_number;
  logic [7:0]  payload_length;
  logic        direct;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (
    output valid, status, frame_kind, channel_number, source_node, dest_node,
           message_id, port_number, payload_length, direct, payload_byte, last,
    input  ready
  );
  modport sink (
    input  valid, status, frame_kind, channel_number, source_node, dest_node,
           message_id, port_number, payload_length, direct, payload_byte, last,
    output ready
  );
endinterface

### rtl/mesh_frame_header_filter_core.sv
// Channel  | Dir | Carries
// ---------+-----+----------------------------------------------------------
// rx       | in  | one frame byte, frame length, first-byte flag
// res      | out | header result, payload byte or reject code, last flag
// apb      | in  | own node id, text kind code, appdata kind code
//
// One byte per cycle unless a stalled result holds the flow: input register, then
// compare/capture logic, then result register. The header verdict is formed
// on the last header byte from the 25 stored header bytes plus that byte.
// rst is synchronous; it resets byte position, frame flags and valid bits.
// A stalled result holds the input stage; rx still takes a byte while it is empty.
`include "mesh_frame_header_filter_core_assert.svh"

module mesh_frame_header_filter_core import mfhf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  mfhf_rx_if.sink            rx,
  mfhf_res_if.source         res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] own_node_id;
  logic [7:0]  text_kind_code;
  logic [7:0]  appdata_kind_code;

  logic [7:0] byte_position;
  logic [7:0] hdr [HDR_STORE_BYTES];
  logic       header_ok;
  logic       frame_accepted;
  logic [7:0] payload_remaining;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [7:0] s1_flen;
  logic       s1_first;

  logic       res_valid;
  res_t       res_q;

  logic       out_free;
  logic       s1_fire;
  logic       cfg_wr;

  logic [7:0]  pos;
  logic        hok;
  logic        facc;
  logic [7:0]  prem;
  logic [15:0] plen;
  logic [31:0] src;
  logic [31:0] dst;
  logic        magic_bad;
  logic        len_bad;
  logic        addr_bad;
  logic        is_text;
  logic        is_app;

  logic        emit;
  res_t        res_next;
  logic        header_ok_next;
  logic        frame_accepted_next;
  logic [7:0]  payload_remaining_next;
  logic [7:0]  byte_position_next;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !res_valid || res.ready;
  assign s1_fire  = s1_valid && out_free;
  assign rx.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id       <= '0;
      text_kind_code    <= 8'd0;
      appdata_kind_code <= 8'd1;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_OWN_NODE:     own_node_id       <= pwdata;
        REG_TEXT_KIND:    text_kind_code    <= pwdata[7:0];
        REG_APPDATA_KIND: appdata_kind_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_OWN_NODE:     prdata = own_node_id;
      REG_TEXT_KIND:    prdata = {24'h0, text_kind_code};
      REG_APPDATA_KIND: prdata = {24'h0, appdata_kind_code};
      default:          prdata = '0;
    endcase
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte  <= rx.rx_byte;
      s1_flen  <= rx.frame_length;
      s1_first <= rx.first_byte;
    end
  end

  // header decode; byte 25 is the byte in the input stage
  assign pos  = s1_first ? 8'd0 : byte_position;
  assign hok  = s1_first ? 1'b1 : header_ok;
  assign facc = s1_first ? 1'b0 : frame_accepted;
  assign prem = s1_first ? 8'd0 : payload_remaining;

  assign plen = {s1_byte, hdr[24]};
  assign src  = {hdr[11], hdr[10], hdr[9], hdr[8]};
  assign dst  = {hdr[15], hdr[14], hdr[13], hdr[12]};

  assign magic_bad = hdr[0] != MAGIC_0 || hdr[1] != MAGIC_1 || hdr[2] != MAGIC_2 ||
                     hdr[3] != MAGIC_3 || hdr[4] != HDR_VERSION;
  assign len_bad   = plen > {8'h00, s1_flen - HDR_BYTES};
  assign addr_bad  = src == own_node_id ||
                     (dst != BCAST_ID && dst != '0 && dst != own_node_id);
  assign is_text   = hdr[5] == text_kind_code;
  assign is_app    = hdr[5] == appdata_kind_code;

  always_comb begin
    emit                   = 1'b0;
    res_next               = '0;
    header_ok_next         = hok;
    frame_accepted_next    = facc;
    payload_remaining_next = prem;

    if (hok && !facc) begin
      if (s1_flen < HDR_BYTES) begin
        if ({1'b0, pos} + 9'd1 >= {1'b0, s1_flen}) begin
          emit            = 1'b1;
          res_next.status = ST_SHORT;
          res_next.last   = 1'b1;
          header_ok_next  = 1'b0;
        end
      end else if (pos == HDR_LAST) begin
        emit          = 1'b1;
        res_next.last = 1'b1;
        if (magic_bad) begin
          res_next.status = ST_BAD_MAGIC;
          header_ok_next  = 1'b0;
        end else if (len_bad) begin
          res_next.status = ST_BAD_LENGTH;
          header_ok_next  = 1'b0;
        end else if (addr_bad) begin
          res_next.status = ST_NOT_ADDR;
          header_ok_next  = 1'b0;
        end else if (!is_text && !is_app) begin
          res_next.status = ST_BAD_KIND;
          header_ok_next  = 1'b0;
        end else begin
          res_next.status         = ST_HEADER;
          res_next.frame_kind     = !is_text;
          res_next.channel_number = hdr[6];
          res_next.source_node    = src;
          res_next.dest_node      = dst;
          res_next.message_id     = {hdr[19], hdr[18], hdr[17], hdr[16]};
          res_next.port_number    = {hdr[23], hdr[22], hdr[21], hdr[20]};
          res_next.payload_length = plen[7:0];
          res_next.direct         = dst == own_node_id;
          res_next.last           = plen == 16'd0;
          frame_accepted_next     = 1'b1;
          payload_remaining_next  = plen[7:0];
        end
      end
    end else if (facc && prem != 8'd0 && pos >= HDR_BYTES) begin
      emit                   = 1'b1;
      payload_remaining_next = prem - 8'd1;
      res_next.status        = ST_PAYLOAD;
      res_next.payload_byte  = s1_byte;
      res_next.last          = prem == 8'd1;
    end

    byte_position_next = (pos < MAX_FRAME_BYTES) ? pos + 8'd1 : MAX_FRAME_BYTES;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      header_ok         <= 1'b1;
      frame_accepted    <= 1'b0;
      payload_remaining <= '0;
    end else if (s1_fire) begin
      byte_position     <= byte_position_next;
      header_ok         <= header_ok_next;
      frame_accepted    <= frame_accepted_next;
      payload_remaining <= payload_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && pos < HDR_LAST) begin
      hdr[pos[4:0]] <= s1_byte;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      res_q <= res_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.status         = res_q.status;
  assign res.frame_kind     = res_q.frame_kind;
  assign res.channel_number = res_q.channel_number;
  assign res.source_node    = res_q.source_node;
  assign res.dest_node      = res_q.dest_node;
  assign res.message_id     = res_q.message_id;
  assign res.port_number    = res_q.port_number;
  assign res.payload_length = res_q.payload_length;
  assign res.direct         = res_q.direct;
  assign res.payload_byte   = res_q.payload_byte;
  assign res.last           = res_q.last;

  `MFHF_ASSERT_IMPLY(a_accepted_not_rejected, frame_accepted, header_ok, "accepted frame marked rejected")
  `MFHF_ASSERT_IMPLY(a_remaining_needs_accept, payload_remaining != 8'd0, frame_accepted, "payload left without accepted frame")
  `MFHF_ASSERT_IMPLY(a_reject_is_last, res_valid && res_q.status != ST_HEADER && res_q.status != ST_PAYLOAD, res_q.last, "reject result without last")
  `MFHF_ASSERT_IMPLY(a_payload_fields_clear, res_valid && res_q.status == ST_PAYLOAD, res_q.source_node == '0 && res_q.payload_length == 8'd0, "payload result carries header fields")
  `MFHF_ASSERT_NEXT(a_input_stage_holds, s1_valid && !out_free, s1_valid && $stable(s1_byte), "input stage dropped a byte")

endmodule

### sim/mesh_frame_header_filter_core_tb.sv
`timescale 1ns / 1ps

module mesh_frame_header_filter_core_tb import mfhf_pkg::*; ();

  typedef logic [7:0] byte_q_t[$];

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  mfhf_rx_if  rx();
  mfhf_res_if res();

  mesh_frame_header_filter_core dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  int unsigned rx_gap_pct;
  int unsigned res_stall_pct;
  int unsigned bad_results  = 0;
  int unsigned rx_transfers = 0;

  res_t pending_filter_results[$];

  // mirror of the filter state and registers
  logic [31:0] node_id      = '0;
  logic [7:0]  text_code    = 8'h00;
  logic [7:0]  appdata_code = 8'h01;
  logic [7:0]  frame_pos    = '0;
  logic [7:0]  hdr_bytes [HDR_BYTES] = '{default: 8'h00};
  logic        hdr_live     = 1'b1;
  logic        frame_taken  = 1'b0;
  logic [7:0]  payload_left = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] hdr_word(int at);
    return {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
  endfunction

  function automatic void filter_rx_byte(logic [7:0] b, logic [7:0] flen, logic first);
    logic [7:0]  p;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] plen;
    res_t        r;
    status_t     why;
    bit          rej;
    bit          emit;
    p = first ? 8'd0 : frame_pos;
    r = '0;
    rej = 1'b0;
    emit = 1'b0;
    why = ST_SHORT;
    if (first) begin
      hdr_live = 1'b1;
      frame_taken = 1'b0;
      payload_left = '0;
    end
    if (p < HDR_BYTES) hdr_bytes[p] = b;
    if (hdr_live && !frame_taken) begin
      if (flen < HDR_BYTES) begin
        if (int'(p) + 1 >= int'(flen)) rej = 1'b1;
      end else if (p == HDR_LAST) begin
        src = hdr_word(8);
        dst = hdr_word(12);
        plen = {hdr_bytes[25], hdr_bytes[24]};
        rej = 1'b1;
        if (hdr_bytes[0] != MAGIC_0 || hdr_bytes[1] != MAGIC_1 || hdr_bytes[2] != MAGIC_2 ||
            hdr_bytes[3] != MAGIC_3 || hdr_bytes[4] != HDR_VERSION) begin
          why = ST_BAD_MAGIC;
        end else if (int'(plen) > int'(flen) - int'(HDR_BYTES)) begin
          why = ST_BAD_LENGTH;
        end else if (src == node_id ||
                     (dst != BCAST_ID && dst != '0 && dst != node_id)) begin
          why = ST_NOT_ADDR;
        end else if (hdr_bytes[5] != text_code && hdr_bytes[5] != appdata_code) begin
          why = ST_BAD_KIND;
        end else begin
          rej = 1'b0;
          emit = 1'b1;
          r.status = ST_HEADER;
          r.frame_kind = (hdr_bytes[5] == text_code) ? 1'b0 : 1'b1;
          r.channel_number = hdr_bytes[6];
          r.source_node = src;
          r.dest_node = dst;
          r.message_id = hdr_word(16);
          r.port_number = hdr_word(20);
          r.payload_length = plen[7:0];
          r.direct = (dst == node_id);
          r.last = (plen == 0);
          frame_taken = 1'b1;
          payload_left = plen[7:0];
        end
      end
    end else if (frame_taken && payload_left != 0 && p >= HDR_BYTES) begin
      payload_left = payload_left - 8'd1;
      emit = 1'b1;
      r.status = ST_PAYLOAD;
      r.payload_byte = b;
      r.last = (payload_left == 0);
    end
    if (rej) begin
      r = '0;
      r.status = why;
      r.last = 1'b1;
      hdr_live = 1'b0;
      emit = 1'b1;
    end
    frame_pos = (p < MAX_FRAME_BYTES) ? p + 8'd1 : MAX_FRAME_BYTES;
    if (emit) pending_filter_results = {pending_filter_results, r};
  endfunction

  function automatic string fmt_result(res_t r);
    return $sformatf({"st=%0d kind=%0d ch=%02h src=%08h dst=%08h id=%08h port=%08h ",
                      "len=%0d dir=%0d byte=%02h last=%0d"},
                     r.status, r.frame_kind, r.channel_number, r.source_node, r.dest_node,
                     r.message_id, r.port_number, r.payload_length, r.direct, r.payload_byte,
                     r.last);
  endfunction

  function automatic void note_error(string msg);
    bad_results++;
    if (bad_results <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void compare_filter_result();
    res_t got;
    res_t want;
    got.status = status_t'(res.status);
    got.frame_kind = res.frame_kind;
    got.channel_number = res.channel_number;
    got.source_node = res.source_node;
    got.dest_node = res.dest_node;
    got.message_id = res.message_id;
    got.port_number = res.port_number;
    got.payload_length = res.payload_length;
    got.direct = res.direct;
    got.payload_byte = res.payload_byte;
    got.last = res.last;
    if (pending_filter_results.size() == 0) begin
      note_error({"unexpected result ", fmt_result(got)});
    end else begin
      want = pending_filter_results[0];
      pending_filter_results.delete(0);
      if (got !== want) begin
        note_error({"result mismatch\n  exp ", fmt_result(want), "\n  got ", fmt_result(got)});
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (rx.valid && rx.ready) begin
        rx_transfers++;
        filter_rx_byte(rx.rx_byte, rx.frame_length, rx.first_byte);
      end
      if (res.valid && res.ready) compare_filter_result();
    end
  end

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= res_stall_pct);
  end

  task automatic send_byte(logic [7:0] b, logic [7:0] flen, logic first);
    while ($urandom_range(99) < rx_gap_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    rx.frame_length <= flen;
    rx.first_byte <= first;
    do @(posedge clk); while (!rx.ready);
  endtask

  task automatic send_frame(byte_q_t q, logic [7:0] flen, bit mark_first = 1'b1);
    foreach (q[i]) send_byte(q[i], flen, mark_first && i == 0);
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    while (pending_filter_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_OWN_NODE:     node_id = val;
      REG_TEXT_KIND:    text_code = val[7:0];
      REG_APPDATA_KIND: appdata_code = val[7:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) begin
      note_error($sformatf("reg %0d readback exp %08h got %08h", idx, val, prdata));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] node, logic [7:0] text, logic [7:0] app);
    drain();
    write_reg(REG_OWN_NODE, node);
    write_reg(REG_TEXT_KIND, {24'd0, text});
    write_reg(REG_APPDATA_KIND, {24'd0, app});
  endtask

  function automatic void put_le32(ref byte_q_t q, input int at, input logic [31:0] v);
    for (int i = 0; i < 4; i++) q[at+i] = v[8*i +: 8];
  endfunction

  function automatic byte_q_t mesh_header(logic [7:0] kind, logic [7:0] chan,
                                          logic [31:0] src, logic [31:0] dst,
                                          logic [31:0] id, logic [31:0] port,
                                          logic [15:0] plen);
    byte_q_t q;
    q = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, HDR_VERSION, kind, chan, 8'($urandom)};
    repeat (16) q = {q, 8'h00};
    put_le32(q, 8, src);
    put_le32(q, 12, dst);
    put_le32(q, 16, id);
    put_le32(q, 20, port);
    q = {q, plen[7:0], plen[15:8]};
    return q;
  endfunction

  task automatic test_no_first_flag();
    byte_q_t q;
    q = mesh_header(8'h01, 8'h3C, 32'h1234_5678, BCAST_ID, 32'hCAFE_0001, 32'h42, 16'd3);
    q = {q, 8'h10, 8'h20, 8'h30};
    send_frame(q, 8'd29, 1'b0);
  endtask

  task automatic test_header_fields();
    byte_q_t q;
    // empty payload: header carries last
    q = mesh_header(8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 16'd0);
    send_frame(q, 8'd26);
    q = mesh_header(8'h01, 8'hFF, 32'h1, BCAST_ID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd4);
    q = {q, 8'h00, 8'hFF, 8'h55, 8'hAA};
    send_frame(q, 8'd255);
    set_config(32'hA5C3_0F96, 8'h00, 8'h01);
    q = mesh_header(8'h00, 8'h5A, 32'h1, 32'hA5C3_0F96, 32'h0102_0304, 32'h8000_0001, 16'd1);
    q = {q, 8'hC3};
    send_frame(q, 8'd27);
    set_config(32'hFFFF_FFFF, 8'h00, 8'h01);
    q = mesh_header(8'h01, 8'h80, 32'h7FFF_FFFF, BCAST_ID, 32'h5555_AAAA, 32'h1, 16'd0);
    send_frame(q, 8'd26);
  endtask

  task automatic test_reject_reasons();
    byte_q_t b;
    byte_q_t q;
    set_config(32'h0000_0100, 8'h00, 8'h01);
    b = mesh_header(8'h01, 8'h07, 32'h0BAD_F00D, BCAST_ID, 32'h5, 32'h6, 16'd2);
    for (int i = 0; i < 5; i += 2) begin
      q = b;
      q[i] ^= 8'h80;
      send_frame(q, 8'd28);
    end
    q = b;
    q[24] = 8'h03;
    send_frame(q, 8'd28);
    q = b;
    q[24] = 8'hFF;
    q[25] = 8'hFF;
    send_frame(q, 8'd28);
    // version beats length, length beats addressing, addressing beats kind
    q = b;
    q[4] = 8'h02;
    q[24] = 8'hFF;
    send_frame(q, 8'd28);
    q = b;
    q[24] = 8'hFF;
    put_le32(q, 8, node_id);
    send_frame(q, 8'd28);
    q = b;
    put_le32(q, 8, node_id);
    q[5] = 8'h09;
    send_frame(q, 8'd28);
    q = b;
    put_le32(q, 12, 32'h0000_0101);
    send_frame(q, 8'd28);
    q = b;
    q[5] = 8'h02;
    send_frame(q, 8'd28);
  endtask

  task automatic test_short_frames();
    byte_q_t q;
    send_byte(MAGIC_0, 8'd0, 1'b1);
    repeat (2) send_byte(8'($urandom), 8'd0, 1'b0);
    send_byte(8'hA7, 8'd1, 1'b1);
    q = mesh_header(8'h01, 8'h01, 32'h2, BCAST_ID, 32'h3, 32'h4, 16'd0);
    void'(q.pop_back());
    send_frame(q, 8'd25);
    repeat (3) send_byte(8'h5A, 8'd25, 1'b0);
    q = {};
    repeat (13) q = {q, 8'($urandom)};
    send_frame(q, 8'd13);
  endtask

  task automatic test_truncated_frames();
    byte_q_t b;
    byte_q_t q;
    b = mesh_header(8'h00, 8'h22, 32'h0000_3333, 32'h0, 32'h44, 32'h55, 16'd2);
    b = {b, 8'h01, 8'h02};
    q = b;
    while (q.size() > 10) void'(q.pop_back());
    send_frame(q, 8'd28);
    send_frame(b, 8'd28);
    q = mesh_header(8'h01, 8'h23, 32'h0000_3334, BCAST_ID, 32'h45, 32'h56, 16'd5);
    q = {q, 8'hF0, 8'hF1};
    send_frame(q, 8'd31);
    send_frame(b, 8'd28);
    // trailing bytes after the payload
    q = mesh_header(8'h00, 8'h24, 32'h0000_3335, 32'h0, 32'h46, 32'h57, 16'd1);
    repeat (4) q = {q, 8'($urandom)};
    send_frame(q, 8'd30);
  endtask

  task automatic test_kind_codes();
    byte_q_t q;
    set_config(32'h0000_0100, 8'h7E, 8'h7E);
    q = mesh_header(8'h7E, 8'h01, 32'h9, BCAST_ID, 32'h1, 32'h2, 16'd1);
    q = {q, 8'h99};
    send_frame(q, 8'd27);
    set_config(32'h0000_0100, 8'hFF, 8'h00);
    q = mesh_header(8'hFF, 8'h02, 32'h9, 32'h0, 32'h1, 32'h2, 16'd0);
    send_frame(q, 8'd26);
    q = mesh_header(8'h00, 8'h03, 32'h9, 32'h0000_0100, 32'h1, 32'h2, 16'd0);
    send_frame(q, 8'd26);
    q = mesh_header(8'h01, 8'h04, 32'h9, 32'h0, 32'h1, 32'h2, 16'd0);
    send_frame(q, 8'd26);
  endtask

  task automatic test_position_limit();
    byte_q_t q;
    set_config(32'h0000_0000, 8'h00, 8'h01);
    q = mesh_header(8'h00, 8'h11, 32'h0000_2000, BCAST_ID, 32'h7, 32'h8, 16'd229);
    repeat (229 + 5) q = {q, 8'($urandom)};
    send_frame(q, 8'd255);
  endtask

  task automatic random_frame();
    byte_q_t     q;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  kind;
    logic [7:0]  flen;
    logic [15:0] bad_len;
    int unsigned sel;
    int unsigned plen;
    int unsigned extra;
    int unsigned n;
    sel = $urandom_range(99);
    plen = ($urandom_range(7) == 0) ? $urandom_range(229) : $urandom_range(10);
    extra = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
    if (plen + extra > 229) extra = 229 - plen;
    flen = 8'(26 + plen + extra);
    src = $urandom;
    if (src == node_id) src = ~src;
    case ($urandom_range(3))
      0: dst = BCAST_ID;
      1: dst = '0;
      2: dst = node_id;
      default: dst = $urandom;
    endcase
    kind = $urandom_range(1) ? text_code : appdata_code;
    q = mesh_header(kind, 8'($urandom), src, dst, $urandom, $urandom, 16'(plen));
    repeat (plen + extra) q = {q, 8'($urandom)};
    if (sel < 58) begin
    end else if (sel < 62) begin
      q[$urandom_range(4)] ^= 8'(1 << $urandom_range(7));
    end else if (sel < 66) begin
      bad_len = 16'($urandom_range(65535, int'(flen) - 25));
      q[24] = bad_len[7:0];
      q[25] = bad_len[15:8];
    end else if (sel < 70) begin
      put_le32(q, 8, node_id);
    end else if (sel < 74) begin
      do dst = $urandom; while (dst == BCAST_ID || dst == '0 || dst == node_id);
      put_le32(q, 12, dst);
    end else if (sel < 78) begin
      do kind = 8'($urandom); while (kind == text_code || kind == appdata_code);
      q[5] = kind;
    end else if (sel < 84) begin
      flen = 8'($urandom_range(25));
      n = ((flen == 0) ? 1 : flen) + $urandom_range(2);
      if ($urandom_range(1)) foreach (q[i]) q[i] = 8'($urandom);
      while (q.size() > n) void'(q.pop_back());
    end else if (sel < 92) begin
      n = $urandom_range(q.size() - 1, 1);
      while (q.size() > n) void'(q.pop_back());
    end else begin
      q = {};
    end
    if (q.size() != 0) begin
      send_frame(q, flen);
    end else begin
      repeat ($urandom_range(40, 1)) begin
        send_byte(8'($urandom), 8'($urandom), $urandom_range(9) == 0);
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned gaps   [4] = '{0, 86, 0, 34};
    int unsigned stalls [4] = '{0, 0, 86, 34};
    int unsigned start;
    bit          paused;
    paused = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config($urandom, 8'($urandom), 8'($urandom));
        1: set_config(32'hFFFF_FFFF, 8'hFF, 8'h00);
        2: begin
          set_config(32'h0, 8'h00, 8'h00);
          set_config(32'h0, text_code + 8'($urandom_range(255, 1)), text_code);
        end
        default: set_config($urandom, 8'h00, 8'hFF);
      endcase
      rx_gap_pct = gaps[ph];
      res_stall_pct = stalls[ph];
      start = rx_transfers;
      while (rx_transfers - start < 20) begin
        random_frame();
        if (ph == 1 && !paused && rx_transfers - start > 10) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    rx.frame_length = '0;
    rx.first_byte = 1'b0;
    rx_gap_pct = 25;
    res_stall_pct = 25;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_first_flag();
    test_header_fields();
    test_reject_reasons();
    test_short_frames();
    test_truncated_frames();
    test_kind_codes();
    test_position_limit();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (bad_results == 0 && pending_filter_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
